// ----- src/fsmda_pkg.sv -----
// package for the single-precision mul/div/add unit
// operation codes, controller states and command/status structs
`timescale 1ns / 1ps
`default_nettype none
package fsmda_pkg;

    localparam int MantW = 24;
    localparam int FracW = 23;
    localparam logic [7:0] Bias = 8'd127;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_ADD = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_NORM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic norm;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic step_last;
        logic norm_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/fsmda_ctrl.sv -----
// controller for the mul/div/add unit
// sequences load, datapath steps and normalization; uses fsmda_pkg
`timescale 1ns / 1ps
`default_nettype none
module fsmda_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire fsmda_pkg::dp_stat_t stat,
    output fsmda_pkg::dp_cmd_t      cmd
);
    import fsmda_pkg::*;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // output register can take a new result when it is empty or its output is not stalled
    logic out_free;
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_CALC;
            ST_CALC: if (stat.step_last) state_next = ST_NORM;
            ST_NORM: if (stat.norm_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        valid_next = valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CALC: cmd.step = 1'b1;
            ST_NORM: cmd.norm = 1'b1;
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = valid_reg;
endmodule
`default_nettype wire

// ----- src/fsmda_dp.sv -----
// datapath for the mul/div/add unit
// operand unpack, shared iterative mantissa unit, normalizer; uses fsmda_pkg
`timescale 1ns / 1ps
`default_nettype none
module fsmda_dp (
    input  wire logic               clk,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        a,
    input  wire logic [31:0]        b,
    input  wire fsmda_pkg::dp_cmd_t cmd,
    output fsmda_pkg::dp_stat_t     stat,
    output logic [31:0]             result
);
    import fsmda_pkg::*;

    op_t         op_reg;
    logic        sign_reg, sign_next;
    logic [7:0]  expo_reg, expo_next;
    logic [48:0] acc_reg, acc_next;   // mul: product, div: remainder, add: sum
    logic [23:0] mb_reg, mb_next;     // multiplicand / divisor
    logic [23:0] q_reg, q_next;       // multiplier bits
    logic [4:0]  cnt_reg, cnt_next;
    logic [25:0] m_reg, m_next;       // mantissa being normalized
    logic        zero_reg, zero_next;
    logic [31:0] res_reg, res_next;

    logic        sa, sb;
    logic [7:0]  ea, eb, ediff_ab, ediff_ba;
    logic [23:0] ma, mb, ma_sh, mb_sh;
    logic [25:0] sa_ext, sb_ext, sum;
    logic [25:0] trial;

    assign sa = a[31];
    assign sb = b[31];
    assign ea = a[30:23];
    assign eb = b[30:23];
    assign ma = {1'b1, a[22:0]};
    assign mb = {1'b1, b[22:0]};
    assign ediff_ab = ea - eb;
    assign ediff_ba = eb - ea;
    assign ma_sh = (ea < eb) ? ((ediff_ba >= 8'd25) ? 24'd0 : ma >> ediff_ba) : ma;
    assign mb_sh = (ea < eb) ? mb : ((ediff_ab >= 8'd25) ? 24'd0 : mb >> ediff_ab);
    assign sa_ext = sa ? -{2'b00, ma_sh} : {2'b00, ma_sh};
    assign sb_ext = sb ? -{2'b00, mb_sh} : {2'b00, mb_sh};
    assign sum    = sa_ext + sb_ext;

    // restoring divide trial: partial remainder against divisor
    assign trial = {1'b0, acc_reg[24:0]} - {2'b00, mb_reg};

    assign stat.step_last = (cnt_reg == 5'd0);
    assign stat.norm_done = zero_reg || (m_reg[25:24] == 2'b00 && m_reg[23]);

    always_ff @(posedge clk)
    begin
        if (cmd.load) op_reg <= op_t'(op);
        sign_reg <= sign_next;
        expo_reg <= expo_next;
        acc_reg  <= acc_next;
        mb_reg   <= mb_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        m_reg    <= m_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        sign_next = sign_reg;
        expo_next = expo_reg;
        acc_next  = acc_reg;
        mb_next   = mb_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        zero_next = zero_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            sign_next = sa ^ sb;
            zero_next = 1'b0;
            mb_next   = mb;
            unique case (op_t'(op))
                OP_MUL:
                begin
                    expo_next = ea + eb - Bias;
                    acc_next  = '0;
                    q_next    = ma;
                    cnt_next  = 5'd23;
                end
                OP_DIV:
                begin
                    expo_next = ea - eb + Bias;
                    // remainder starts at ma, one quotient bit per step, msb first
                    acc_next  = {25'd0, ma};
                    q_next    = ma;
                    m_next    = '0;
                    cnt_next  = 5'd23;
                end
                OP_ADD:
                begin
                    expo_next = (ea < eb) ? eb : ea;
                    sign_next = sum[25];
                    acc_next  = {23'd0, sum[25] ? -sum : sum};
                    zero_next = (sum == 26'd0);
                    cnt_next  = 5'd0;
                end
                default:
                begin
                    zero_next = 1'b1;
                    cnt_next  = 5'd0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (!stat.step_last) cnt_next = cnt_reg - 5'd1;
            unique case (op_reg)
                OP_MUL:
                begin
                    // shift-add, lsb first; product ends up in acc[48:1]
                    if (q_reg[0])
                        acc_next = {1'b0, acc_reg[48:1]} + {1'b0, mb_reg, 24'd0};
                    else
                        acc_next = {1'b0, acc_reg[48:1]};
                    q_next = {1'b0, q_reg[23:1]};
                    if (stat.step_last)
                        m_next = {1'b0, acc_next[48:24]};
                end
                OP_DIV:
                begin
                    // keep the difference when it does not go negative
                    if (!trial[25])
                        acc_next = {24'd0, trial[23:0], 1'b0};
                    else
                        acc_next = {24'd0, acc_reg[23:0], 1'b0};
                    m_next = {m_reg[24:0], !trial[25]};
                end
                OP_ADD:
                begin
                    m_next = acc_reg[25:0];
                end
                default: ;
            endcase
        end
        else if (cmd.norm)
        begin
            if (m_reg == 26'd0) zero_next = zero_reg || (op_reg == OP_ADD);
            if (!stat.norm_done)
            begin
                if (m_reg[25:24] != 2'b00)
                begin
                    m_next    = {1'b0, m_reg[25:1]};
                    expo_next = expo_reg + 8'd1;
                end
                else if (m_reg == 26'd0)
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    m_next    = {m_reg[24:0], 1'b0};
                    expo_next = expo_reg - 8'd1;
                end
            end
        end
        if (cmd.out_load)
            res_next = (zero_reg && op_reg != OP_DIV) ? 32'd0
                     : {sign_reg, expo_reg, m_reg[22:0]};
    end

    assign result = res_reg;
endmodule
`default_nettype wire

// ----- src/float_single_mul_div_add_unit.sv -----
// top level of the single-precision mul/div/add unit
// joins fsmda_ctrl and fsmda_dp; uses fsmda_pkg
`timescale 1ns / 1ps
`default_nettype none
// usage:
//   input channel cmd/operand_a/operand_b with in_valid/in_stall; one
//   transaction gives one result_bits on the output channel (out_valid,
//   out_stall). cmd 0 multiply, 1 divide, 2 add, 3 gives zero.
// sequence:
//   multiply and divide step once per multiplier or quotient bit (one bit
//   a cycle), then normalize and load the output register. add and cmd 3
//   pass through the step state once, normalize one shift at a time, then
//   load the output register.
//   one transaction is in flight at a time; the next is taken in the cycle
//   after the result moves into the output register.
// reset:
//   rst_n clears the controller and output valid; no result is pending.
// stall:
//   a stalled result holds in the output register; the core finishes its
//   transaction and waits until the register frees.
module float_single_mul_div_add_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_bits
);
    import fsmda_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    fsmda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    fsmda_dp u_dp (
        .clk    (clk),
        .op     (cmd),
        .a      (operand_a),
        .b      (operand_b),
        .cmd    (dcmd),
        .stat   (dstat),
        .result (result_bits)
    );
endmodule
`default_nettype wire
